// File: rtl/core/c8_pkg.sv
`default_nettype none
package c8_pkg;

   localparam int MEM_BYTES   = 4096;
   localparam int STACK_DEPTH = 16;
   localparam int SP_W        = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam logic [11:0] PC_RESET = 12'h200;
   localparam int FONT_BYTES  = 80;

   // commands
   localparam logic [1:0] CMD_STEP  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   // controller phases
   typedef enum logic [10:0] {
      ST_IDLE   = 11'b00000000001,
      ST_FETCH0 = 11'b00000000010,
      ST_FETCH1 = 11'b00000000100,
      ST_FETCH2 = 11'b00000001000,
      ST_EXEC   = 11'b00000010000,
      ST_LOOP   = 11'b00000100000,
      ST_LOOPW  = 11'b00001000000,
      ST_SPR    = 11'b00010000000,
      ST_CLEAR  = 11'b00100000000,
      ST_DONE   = 11'b01000000000,
      ST_INIT   = 11'b10000000000
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic       init_step;   // font load / memory and frame buffer clear sweep
      logic       capture;     // latch request fields
      logic       fetch_hi;    // issue fetch of high byte
      logic       fetch_lo;    // latch high, issue low
      logic       fetch_end;   // latch low byte
      logic       exec;        // execute: update registers, PC and timers
      logic       loop_step;   // one step of a BCD / store / load instruction
      logic       spr_step;    // one sprite step (one phase of a pixel row)
      logic       clr_step;    // frame clear step
      logic       finish;      // load the output register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic       init_done;
      logic       is_step;
      logic       need_loop;   // BCD / store / load
      logic       need_spr;
      logic       need_clr;
      logic       loop_last;
      logic       spr_last;
      logic       clr_last;
   } stat_type;

   function automatic logic [7:0] font_byte(input logic [6:0] a);
      logic [7:0] f [0:79];
      f = '{8'hF0,8'h90,8'h90,8'h90,8'hF0, 8'h20,8'h60,8'h20,8'h20,8'h70,
            8'hF0,8'h10,8'hF0,8'h80,8'hF0, 8'hF0,8'h10,8'hF0,8'h10,8'hF0,
            8'h90,8'h90,8'hF0,8'h10,8'h10, 8'hF0,8'h80,8'hF0,8'h10,8'hF0,
            8'hF0,8'h80,8'hF0,8'h90,8'hF0, 8'hF0,8'h10,8'h20,8'h40,8'h40,
            8'hF0,8'h90,8'hF0,8'h90,8'hF0, 8'hF0,8'h90,8'hF0,8'h10,8'hF0,
            8'hF0,8'h90,8'hF0,8'h90,8'h90, 8'hE0,8'h90,8'hE0,8'h90,8'hE0,
            8'hF0,8'h80,8'h80,8'h80,8'hF0, 8'hE0,8'h90,8'h90,8'h90,8'hE0,
            8'hF0,8'h80,8'hF0,8'h80,8'hF0, 8'hF0,8'h80,8'hF0,8'h80,8'h80};
      return (a < 7'd80) ? f[a] : 8'h00;
   endfunction

endpackage
`default_nettype wire

// File: rtl/core/c8_ctrl.sv
`default_nettype none
module c8_ctrl
   import c8_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_stall,
   output logic          rsp_valid,
   input  wire logic     rsp_stall,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_stall = !(state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // next state
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      unique case (state_ff)
         ST_INIT: begin
            cmd.init_step = 1'b1;
            if (stat.init_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in = ST_FETCH0;
            end
         end
         ST_FETCH0: begin
            if (stat.is_step) begin
               cmd.fetch_hi = 1'b1;
               state_in = ST_FETCH1;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_FETCH1: begin
            cmd.fetch_lo = 1'b1;
            state_in = ST_FETCH2;
         end
         ST_FETCH2: begin
            cmd.fetch_end = 1'b1;
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (stat.need_loop) state_in = ST_LOOP;
            else if (stat.need_spr) state_in = ST_SPR;
            else if (stat.need_clr) state_in = ST_CLEAR;
            else begin
               cmd.exec = 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_LOOP: begin
            cmd.loop_step = 1'b1;
            state_in = ST_LOOPW;
         end
         ST_LOOPW: begin
            // memory read latency slot
            cmd.loop_step = 1'b1;
            if (stat.loop_last) begin
               cmd.exec = 1'b1;
               state_in = ST_DONE;
            end else state_in = ST_LOOP;
         end
         ST_SPR: begin
            cmd.spr_step = 1'b1;
            if (stat.spr_last) begin
               cmd.exec = 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (stat.clr_last) begin
               cmd.exec = 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/core/c8_datapath.sv
`default_nettype none
module c8_datapath
   import c8_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cmd_type     cmd,
   output stat_type         stat,
   input  wire logic [1:0]  req_command,
   input  wire logic [11:0] req_address,
   input  wire logic [7:0]  req_write_byte,
   input  wire logic [15:0] req_keypad,
   input  wire logic [7:0]  req_random_byte,
   output logic [11:0]      rsp_program_counter,
   output logic [15:0]      rsp_fetched_opcode,
   output logic [7:0]       rsp_read_data,
   output logic             rsp_draw_pending,
   output logic             rsp_sound_on,
   output logic             rsp_key_wait,
   output logic             rsp_bad_opcode
);

   // main memory, one port
   logic [7:0]  mem [0:MEM_BYTES-1];
   logic [11:0] mem_addr;
   logic        mem_we;
   logic [7:0]  mem_wdata;
   logic [7:0]  mem_rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_addr] <= mem_wdata;
      mem_rdata_ff <= mem[mem_addr];
   end

   // frame buffer, 256 bytes of 8 pixels (32 rows of 64 pixels), one port
   logic [7:0] fb [0:255];
   logic [7:0] fb_addr;
   logic       fb_we;
   logic [7:0] fb_wdata;
   logic [7:0] fb_rdata_ff;

   always_ff @(posedge clock) begin
      if (fb_we) fb[fb_addr] <= fb_wdata;
      fb_rdata_ff <= fb[fb_addr];
   end

   // architectural state
   logic [7:0]  v_ff [0:15];
   logic [11:0] stk_ff [0:STACK_DEPTH-1];
   logic [SP_W-1:0] sp_ff;
   logic [11:0] pc_ff, idx_ff;
   logic [7:0]  dt_ff, st_ff;
   logic        redraw_ff;

   // latched request
   logic [1:0]  c_cmd_ff;
   logic [11:0] c_addr_ff;
   logic [7:0]  c_wb_ff, c_rnd_ff;
   logic [15:0] c_keys_ff;
   logic [7:0]  op_hi_ff;
   logic [15:0] op_ff;

   // per-transaction status, copied to the outputs on finish
   logic        key_wait_ff;
   logic        bad_op_ff;

   // sequencing
   logic [11:0] init_cnt_ff;
   logic [4:0]  cnt_ff;      // loop / sprite step counter
   logic [1:0]  sub_ff;      // sprite phase / loop write-read phase
   logic        spr_half_ff; // sprite pass over the right-hand byte
   logic [7:0]  clr_cnt_ff;
   logic        hit_ff;
   logic [7:0]  bcd_h, bcd_t, bcd_o;
   logic [7:0]  bcd_rem;
   logic [15:0] bcd_prod;
   logic [7:0]  spr_row_ff;

   logic [3:0] x, y, n;
   logic [7:0] nn, vx, vy;
   assign x  = op_ff[11:8];
   assign y  = op_ff[7:4];
   assign n  = op_ff[3:0];
   assign nn = op_ff[7:0];
   assign vx = v_ff[x];
   assign vy = v_ff[y];

   logic is_loop_op, is_spr_op, is_clr_op;
   assign is_loop_op = (op_ff[15:12] == 4'hF) &&
                       (nn == 8'h33 || nn == 8'h55 || nn == 8'h65);
   assign is_spr_op  = (op_ff[15:12] == 4'hD) && (n != 4'h0);
   assign is_clr_op  = (op_ff == 16'h00E0);

   logic [4:0] loop_len;
   assign loop_len = (nn == 8'h33) ? 5'd3 : ({1'b0, x} + 5'd1);

   // BCD digits: hundreds by compare, tens by multiply with 205 and shift by 11
   always_comb begin
      bcd_h    = (vx >= 8'd200) ? 8'd2 : ((vx >= 8'd100) ? 8'd1 : 8'd0);
      bcd_rem  = vx - ((vx >= 8'd200) ? 8'd200 : ((vx >= 8'd100) ? 8'd100 : 8'd0));
      bcd_prod = {8'd0, bcd_rem} * 16'd205;
      bcd_t    = {4'd0, bcd_prod[14:11]};
      bcd_o    = bcd_rem - {bcd_t[4:0], 3'd0} - {bcd_t[6:0], 1'b0};
   end

   // sprite geometry
   logic [5:0] spr_x;
   logic [4:0] spr_y;
   logic [2:0] shft;
   logic [15:0] spr_wide;
   logic [7:0] row_a, row_b, cur_row;
   logic [7:0] addr_a, addr_b, cur_addr;
   assign spr_x    = vx[5:0];
   assign spr_y    = vy[4:0] + cnt_ff[4:0];
   assign shft     = spr_x[2:0];
   assign spr_wide = {spr_row_ff, 8'h00} >> shft;
   assign row_a    = spr_wide[15:8];
   assign row_b    = spr_wide[7:0];
   assign addr_a   = {spr_y, spr_x[5:3]};
   assign addr_b   = {spr_y, spr_x[5:3] + 3'd1};
   assign cur_row  = spr_half_ff ? row_b : row_a;
   assign cur_addr = spr_half_ff ? addr_b : addr_a;

   // memory / frame buffer port control
   always_comb begin
      mem_addr  = pc_ff;
      mem_we    = 1'b0;
      mem_wdata = c_wb_ff;
      fb_addr   = c_addr_ff[7:0];
      fb_we     = 1'b0;
      fb_wdata  = 8'h00;
      if (cmd.init_step) begin
         mem_addr  = init_cnt_ff;
         mem_we    = 1'b1;
         mem_wdata = font_byte(init_cnt_ff[6:0]) &
                     {8{init_cnt_ff < 12'(FONT_BYTES)}};
         fb_addr   = init_cnt_ff[7:0];
         fb_we     = 1'b1;
      end else if (cmd.fetch_hi) begin
         mem_addr = pc_ff;
      end else if (cmd.fetch_lo) begin
         mem_addr = pc_ff + 12'd1;
      end else if (cmd.loop_step) begin
         mem_addr = idx_ff + {7'd0, cnt_ff};
         if (!sub_ff[0] && nn != 8'h65) begin
            mem_we = 1'b1;
            if (nn == 8'h33)
               mem_wdata = (cnt_ff == 5'd0) ? bcd_h :
                           ((cnt_ff == 5'd1) ? bcd_t : bcd_o);
            else
               mem_wdata = v_ff[cnt_ff[3:0]];
         end
      end else if (cmd.spr_step) begin
         unique case (sub_ff)
            2'd0: mem_addr = idx_ff + {7'd0, cnt_ff};
            2'd1: fb_addr = cur_addr;
            2'd2: begin
               fb_addr  = cur_addr;
               fb_we    = 1'b1;
               fb_wdata = fb_rdata_ff ^ cur_row;
            end
            default: ;
         endcase
      end else if (cmd.clr_step) begin
         fb_addr = clr_cnt_ff;
         fb_we   = 1'b1;
      end else if (c_cmd_ff == CMD_WRITE && cmd.finish) begin
         mem_addr = c_addr_ff;
         mem_we   = 1'b1;
      end
   end

   assign stat.init_done = (init_cnt_ff == 12'(MEM_BYTES - 1));
   assign stat.is_step   = (c_cmd_ff == CMD_STEP);
   assign stat.need_loop = is_loop_op;
   assign stat.need_spr  = is_spr_op;
   assign stat.need_clr  = is_clr_op;
   assign stat.loop_last = (cnt_ff == loop_len - 5'd1);
   assign stat.spr_last  = (sub_ff == 2'd3) && (spr_half_ff || shft == 3'd0) &&
                           (cnt_ff == {1'b0, n} - 5'd1);
   assign stat.clr_last  = (clr_cnt_ff == 8'hFF);

   // key scan: highest held key
   logic [3:0] key_hi;
   logic       key_any;
   always_comb begin
      key_hi  = 4'd0;
      key_any = |c_keys_ff;
      for (int k = 0; k < 16; k++)
         if (c_keys_ff[k]) key_hi = 4'(k);
   end

   // execute
   logic [11:0] nxt, skp;
   assign nxt = pc_ff + 12'd2;
   assign skp = pc_ff + 12'd4;

   always_ff @(posedge clock) begin
      logic [8:0] sum;
      logic       bad, wait_k, tick;
      logic [11:0] pc_n;
      logic [SP_W-1:0] sp_m1;
      if (reset) begin
         init_cnt_ff <= 12'd0;
         for (int k = 0; k < 16; k++) v_ff[k] <= 8'd0;
         for (int k = 0; k < STACK_DEPTH; k++) stk_ff[k] <= 12'd0;
         sp_ff     <= '0;
         pc_ff     <= PC_RESET;
         idx_ff    <= 12'd0;
         dt_ff     <= 8'd0;
         st_ff     <= 8'd0;
         redraw_ff <= 1'b1;
      end else begin
         if (cmd.capture) begin
            c_cmd_ff  <= req_command;
            c_addr_ff <= req_address;
            c_wb_ff   <= req_write_byte;
            c_keys_ff <= req_keypad;
            c_rnd_ff  <= req_random_byte;
            op_ff     <= 16'h0000;
            cnt_ff    <= 5'd0;
            sub_ff    <= 2'd0;
            clr_cnt_ff <= 8'd0;
            hit_ff    <= 1'b0;
            spr_half_ff <= 1'b0;
            key_wait_ff <= 1'b0;
            bad_op_ff   <= 1'b0;
         end
         if (cmd.fetch_lo) op_hi_ff <= mem_rdata_ff;
         if (cmd.fetch_end) op_ff <= {op_hi_ff, mem_rdata_ff};
         if (cmd.clr_step) clr_cnt_ff <= clr_cnt_ff + 8'd1;
         if (cmd.loop_step) begin
            if (sub_ff[0]) begin
               if (nn == 8'h65) v_ff[cnt_ff[3:0]] <= mem_rdata_ff;
               cnt_ff <= cnt_ff + 5'd1;
            end
            sub_ff <= {1'b0, ~sub_ff[0]};
         end
         if (cmd.spr_step) begin
            unique case (sub_ff)
               2'd0: sub_ff <= 2'd1;
               2'd1: begin
                  if (!spr_half_ff) spr_row_ff <= mem_rdata_ff;
                  sub_ff <= 2'd2;
               end
               2'd2: begin
                  if ((fb_rdata_ff & cur_row) != 8'h00) hit_ff <= 1'b1;
                  sub_ff <= 2'd3;
               end
               default: begin
                  if (!spr_half_ff && shft != 3'd0) begin
                     // second pass over the byte to the right
                     spr_half_ff <= 1'b1;
                     sub_ff      <= 2'd1;
                  end else begin
                     spr_half_ff <= 1'b0;
                     sub_ff      <= 2'd0;
                     cnt_ff      <= cnt_ff + 5'd1;
                  end
               end
            endcase
         end
         if (cmd.finish) begin
            rsp_program_counter <= pc_ff;
            rsp_fetched_opcode  <= op_ff;
            rsp_read_data       <= (c_cmd_ff == CMD_READ) ? fb_rdata_ff : 8'h00;
            rsp_draw_pending    <= (c_cmd_ff == CMD_READ) ? 1'b0 : redraw_ff;
            rsp_sound_on        <= (st_ff != 8'd0);
            rsp_key_wait        <= key_wait_ff;
            rsp_bad_opcode      <= bad_op_ff;
         end
         if (cmd.exec) begin
            bad    = 1'b0;
            wait_k = 1'b0;
            tick   = 1'b1;
            pc_n   = nxt;
            sp_m1  = sp_ff - SP_W'(1);
            unique case (op_ff[15:12])
               4'h0: begin
                  if (op_ff == 16'h00E0) redraw_ff <= 1'b1;
                  else if (op_ff == 16'h00EE) begin
                     sp_ff <= sp_m1;
                     pc_n = stk_ff[sp_m1] + 12'd2;
                  end else bad = 1'b1;
               end
               4'h1: pc_n = op_ff[11:0];
               4'h2: begin
                  stk_ff[sp_ff] <= pc_ff;
                  sp_ff <= sp_ff + SP_W'(1);
                  pc_n = op_ff[11:0];
               end
               4'h3: pc_n = (vx == nn) ? skp : nxt;
               4'h4: pc_n = (vx != nn) ? skp : nxt;
               4'h5: pc_n = (vx == vy) ? skp : nxt;
               4'h6: v_ff[x] <= nn;
               4'h7: v_ff[x] <= vx + nn;
               4'h8: begin
                  // the flag wins when X is F
                  unique case (n)
                     4'h0: v_ff[x] <= vy;
                     4'h1: v_ff[x] <= vx | vy;
                     4'h2: v_ff[x] <= vx & vy;
                     4'h3: v_ff[x] <= vx ^ vy;
                     4'h4: begin
                        sum = {1'b0, vx} + {1'b0, vy};
                        if (x != 4'hF) v_ff[x] <= sum[7:0];
                        v_ff[15] <= {7'd0, sum[8]};
                     end
                     4'h5: begin
                        if (x != 4'hF) v_ff[x] <= vx - vy;
                        v_ff[15] <= {7'd0, vx >= vy};
                     end
                     4'h6: begin
                        if (x != 4'hF) v_ff[x] <= {1'b0, vx[7:1]};
                        v_ff[15] <= {7'd0, vx[0]};
                     end
                     4'h7: begin
                        if (x != 4'hF) v_ff[x] <= vy - vx;
                        v_ff[15] <= {7'd0, vy >= vx};
                     end
                     4'hE: begin
                        if (x != 4'hF) v_ff[x] <= {vx[6:0], 1'b0};
                        v_ff[15] <= {7'd0, vx[7]};
                     end
                     default: bad = 1'b1;
                  endcase
               end
               4'h9: pc_n = (vx != vy) ? skp : nxt;
               4'hA: idx_ff <= op_ff[11:0];
               4'hB: pc_n = op_ff[11:0] + {4'd0, v_ff[0]};
               4'hC: v_ff[x] <= c_rnd_ff & nn;
               4'hD: begin
                  v_ff[15] <= {7'd0, hit_ff};
                  redraw_ff <= 1'b1;
               end
               4'hE: begin
                  if (nn == 8'h9E) pc_n = c_keys_ff[vx[3:0]] ? skp : nxt;
                  else if (nn == 8'hA1) pc_n = c_keys_ff[vx[3:0]] ? nxt : skp;
                  else bad = 1'b1;
               end
               default: begin
                  unique case (nn)
                     8'h07: v_ff[x] <= dt_ff;
                     8'h0A: begin
                        if (key_any) v_ff[x] <= {4'd0, key_hi};
                        else begin
                           wait_k = 1'b1;
                           tick   = 1'b0;
                           pc_n   = pc_ff;
                        end
                     end
                     8'h15: ;
                     8'h18: ;
                     8'h1E: idx_ff <= idx_ff + {4'd0, vx};
                     8'h29: idx_ff <= {4'd0, vx} * 12'd5;
                     8'h33, 8'h55, 8'h65: ;
                     default: bad = 1'b1;
                  endcase
               end
            endcase
            pc_ff <= pc_n;
            key_wait_ff <= wait_k;
            bad_op_ff   <= bad;
            if (op_ff[15:12] == 4'hF && nn == 8'h15)
               dt_ff <= (vx != 8'd0) ? vx - 8'd1 : 8'd0;
            else if (tick && dt_ff != 8'd0) dt_ff <= dt_ff - 8'd1;
            if (op_ff[15:12] == 4'hF && nn == 8'h18)
               st_ff <= (vx != 8'd0) ? vx - 8'd1 : 8'd0;
            else if (tick && st_ff != 8'd0) st_ff <= st_ff - 8'd1;
         end
         if (cmd.finish && c_cmd_ff == CMD_READ) redraw_ff <= 1'b0;
         if (cmd.init_step) init_cnt_ff <= init_cnt_ff + 12'd1;
      end
   end

endmodule
`default_nettype wire

// File: rtl/core/chip8_instruction_step.sv
// Write and read go from capture to response; a step fetches the opcode and
// executes; BCD/store/load add a write or read per byte, draw a sprite read
// and frame-buffer read-modify-writes per row, clear a write per display byte.
// One transaction at a time. Reset (synchronous): a sweep of memory loads the
// font, zeroes memory, clears the display; req_stall stays high until it ends.
`default_nettype none
module chip8_instruction_step
   import c8_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_command,
   input  wire logic [11:0] req_address,
   input  wire logic [7:0]  req_write_byte,
   input  wire logic [15:0] req_keypad,
   input  wire logic [7:0]  req_random_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [11:0]      rsp_program_counter,
   output logic [15:0]      rsp_fetched_opcode,
   output logic [7:0]       rsp_read_data,
   output logic             rsp_draw_pending,
   output logic             rsp_sound_on,
   output logic             rsp_key_wait,
   output logic             rsp_bad_opcode
);

   cmd_type  cmd;
   stat_type stat;

   c8_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .stat, .cmd
   );

   c8_datapath u_dp (
      .clock, .reset, .cmd, .stat,
      .req_command, .req_address, .req_write_byte, .req_keypad, .req_random_byte,
      .rsp_program_counter, .rsp_fetched_opcode, .rsp_read_data,
      .rsp_draw_pending, .rsp_sound_on, .rsp_key_wait, .rsp_bad_opcode
   );

endmodule
`default_nettype wire
